/* src/next_prime_finder_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef NEXT_PRIME_FINDER_CORE_ASSERT_SVH
`define NEXT_PRIME_FINDER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define NPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define NPF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/npf_pkg.sv */
`default_nettype none
package npf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CAND_W      = VALUE_WIDTH + 1;
  // Trial divisors never run far past the square root of the candidate
  localparam int DIV_W       = (CAND_W + 1) / 2 + 1;
  localparam int CNT_W       = $clog2(CAND_W + 1);
  localparam int NIB_CNT     = (VALUE_WIDTH + 3) / 4;
  localparam int NIB_W       = NIB_CNT * 4;
  localparam int NSUM_W      = 8;

  localparam logic [4:0] SMALL_LIMIT = 5'd29;
  localparam logic [5:0] WHEEL_WRAP  = 6'd31;
  localparam logic [4:0] FIRST_TRIAL = 5'd7;
  localparam logic [2:0] FIRST_TRIAL_IDX = 3'd1;
  localparam logic [4:0] MOD15       = 5'd15;
  localparam logic [4:0] MOD15_X2    = 5'd30;

  localparam logic [4:0] LOW_PRIME [10] = '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11,
                                            5'd13, 5'd17, 5'd19, 5'd23, 5'd29};
  localparam logic [4:0] WHEEL_RESIDUE [8] = '{5'd1, 5'd7, 5'd11, 5'd13,
                                               5'd17, 5'd19, 5'd23, 5'd29};
  localparam logic [2:0] WHEEL_STEP [8] = '{3'd6, 3'd4, 3'd2, 3'd4,
                                            3'd2, 3'd4, 3'd6, 3'd2};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KSTART,
    ST_SETUP,
    ST_TSTART,
    ST_TWAIT,
    ST_FINISH
  } npf_state_t;

  typedef struct packed {
    logic load;
    logic k_start;
    logic setup;
    logic test_start;
    logic next_div;
    logic next_cand;
    logic out_load;
  } npf_cmd_t;

  typedef struct packed {
    logic low_value;
    logic div_done;
    logic cand_prime;
    logic is_comp;
    logic out_free;
  } npf_stat_t;

  // First prime above a value below 29
  function automatic logic [4:0] small_next(input logic [4:0] n);
    logic [4:0] res;
    res = LOW_PRIME[9];
    for (int i = 9; i >= 0; i--) begin
      if (LOW_PRIME[i] > n) res = LOW_PRIME[i];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/next_prime_finder_core.sv */
// From taken request to out_valid: values below 29 go straight to the finish state; others
// are moved onto the wheel, then each trial division is started, run on the serial divider
// and decided, for every divisor of every candidate walked; a stalled output holds it back.
// Throughput: one request at a time; the next is taken the cycle after the result loads.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous, active low; clears the controller, divider and output valid.
`default_nettype none
module next_prime_finder_core
  import npf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VALUE_WIDTH-1:0] in_start_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CAND_W-1:0]           out_prime_value
);

  npf_cmd_t  cmd;
  npf_stat_t stat;

  npf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .start_value (in_start_value),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .prime_value (out_prime_value)
  );

endmodule
`default_nettype wire

/* src/npf_div.sv */
`default_nettype none
module npf_div
  import npf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CAND_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]  divisor,
  output logic                   done,
  output logic [CAND_W-1:0]      quotient,
  output logic [DIV_W-1:0]       remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CAND_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W:0]    trial;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[CAND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(CAND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[CAND_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[CAND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

/* src/npf_datapath.sv */
`default_nettype none
module npf_datapath
  import npf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire npf_cmd_t               cmd,
  output npf_stat_t                   stat,
  input  wire logic [VALUE_WIDTH-1:0] start_value,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [CAND_W-1:0]           prime_value
);

  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [2:0]        cidx_r, cidx_nxt;
  logic [2:0]        didx_r, didx_nxt;
  logic              small_r, small_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CAND_W-1:0] out_r, out_nxt;
  logic [NSUM_W-1:0] nsum_r, nsum_nxt;

  logic              in_small;
  logic              div_start;
  logic              div_done;
  logic [CAND_W-1:0] div_quo;
  logic [DIV_W-1:0]  div_rem;

  logic [NIB_W-1:0]  val_ext;
  logic [NSUM_W-1:0] nsum;
  logic [4:0]        fold;
  logic [4:0]        r15;
  logic [4:0]        rem5;
  logic [2:0]        res_idx;
  logic              res_found;
  logic [5:0]        offset;

  assign in_small  = start_value < VALUE_WIDTH'(SMALL_LIMIT);
  assign div_start = cmd.test_start;

  npf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (cand_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Value mod 15 by nibble sum (16 is 1 mod 15); bit 0 then picks the residue mod 30
  always_comb begin
    val_ext = NIB_W'(cand_r[VALUE_WIDTH-1:0]);
    nsum    = '0;
    for (int i = 0; i < NIB_CNT; i++) nsum = nsum + NSUM_W'(val_ext[4*i +: 4]);
    fold = {1'b0, nsum_r[NSUM_W-1:4]} + {1'b0, nsum_r[3:0]};
    if (fold >= MOD15_X2)   r15 = fold - MOD15_X2;
    else if (fold >= MOD15) r15 = fold - MOD15;
    else                    r15 = fold;
    rem5 = (r15[0] == cand_r[0]) ? r15 : r15 + MOD15;
  end

  // Offset from the value to the first wheel candidate above it
  always_comb begin
    res_idx   = 3'd0;
    res_found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (WHEEL_RESIDUE[i] > rem5) begin
        res_idx   = 3'(i);
        res_found = 1'b1;
      end
    end
    if (res_found) offset = {1'b0, WHEEL_RESIDUE[res_idx]} - {1'b0, rem5};
    else           offset = WHEEL_WRAP - {1'b0, rem5};
  end

  always_comb begin
    cand_nxt      = cand_r;
    d_nxt         = d_r;
    cidx_nxt      = cidx_r;
    didx_nxt      = didx_r;
    small_nxt     = small_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    nsum_nxt      = nsum_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) begin
      small_nxt = in_small;
      cand_nxt  = in_small ? CAND_W'(small_next(start_value[4:0]))
                           : {1'b0, start_value};
    end
    if (cmd.k_start) nsum_nxt = nsum;
    if (cmd.setup) begin
      cand_nxt = cand_r + CAND_W'(offset);
      cidx_nxt = res_idx;
      d_nxt    = DIV_W'(FIRST_TRIAL);
      didx_nxt = FIRST_TRIAL_IDX;
    end
    if (cmd.next_div) begin
      d_nxt    = d_r + DIV_W'(WHEEL_STEP[didx_r]);
      didx_nxt = didx_r + 3'd1;
    end
    if (cmd.next_cand) begin
      cand_nxt = cand_r + CAND_W'(WHEEL_STEP[cidx_r]);
      cidx_nxt = cidx_r + 3'd1;
      d_nxt    = DIV_W'(FIRST_TRIAL);
      didx_nxt = FIRST_TRIAL_IDX;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    cand_r  <= cand_nxt;
    d_r     <= d_nxt;
    cidx_r  <= cidx_nxt;
    didx_r  <= didx_nxt;
    small_r <= small_nxt;
    out_r   <= out_nxt;
    nsum_r  <= nsum_nxt;
  end

  assign stat.low_value  = small_r;
  assign stat.div_done   = div_done;
  assign stat.cand_prime = div_quo < CAND_W'(d_r);
  assign stat.is_comp    = div_rem == '0;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign prime_value = out_r;

endmodule
`default_nettype wire

/* src/npf_ctrl.sv */
`default_nettype none
module npf_ctrl
  import npf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire npf_stat_t stat,
  output npf_cmd_t       cmd
);

  npf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_KSTART;
        end
      end
      ST_KSTART: begin
        if (stat.low_value) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.k_start = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_TSTART;
      end
      ST_TSTART: begin
        cmd.test_start = 1'b1;
        state_nxt      = ST_TWAIT;
      end
      ST_TWAIT: begin
        // Quotient below divisor settles prime before the remainder is looked at
        if (stat.div_done) begin
          if (stat.cand_prime) begin
            state_nxt = ST_FINISH;
          end else if (stat.is_comp) begin
            cmd.next_cand = 1'b1;
            state_nxt     = ST_TSTART;
          end else begin
            cmd.next_div = 1'b1;
            state_nxt    = ST_TSTART;
          end
        end
      end
      ST_FINISH: begin
        // Hold until the output register can take the result
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/npf_checker.sv */
`default_nettype none
`include "next_prime_finder_core_assert.svh"
module npf_checker
  import npf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [VALUE_WIDTH-1:0] in_start_value,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [CAND_W-1:0]      out_prime_value
);

  `NPF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_prime_value), "result dropped or changed while stalled")
  `NPF_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_start_value), "request dropped or changed while waiting")
  `NPF_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready, "request taken while a search is running")
  `NPF_ASSERT(a_prime_shape, out_valid |-> out_prime_value[0] || out_prime_value == CAND_W'(2), "even result other than two")
  `NPF_ASSERT_RST(a_reset_clear, rst_n && $past(!rst_n) |-> !out_valid, "result valid straight after reset")

endmodule

bind next_prime_finder_core npf_checker u_npf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_start_value  (in_start_value),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_prime_value (out_prime_value)
);
`default_nettype wire
